// ----- design/wcrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wcrc_pkg;

    // Widths fixed by the register map and the stream fields
    localparam int CFG_W  = 13;
    localparam int WORD_W = 16;
    localparam int IDX_SEL_W = 2;

    // Default word-index ceiling
    localparam int MAX_WORDS_DEF = 4096;

    // CRC-16 polynomial (x^16 + x^15 + x^2 + 1), MSB first
    localparam logic [WORD_W-1:0] CRC_POLY = 16'h8005;

    // Register reset values
    localparam logic [CFG_W-1:0] SKIP_BEGIN_RST  = 13'd216;
    localparam logic [CFG_W-1:0] SKIP_END_RST    = 13'd256;
    localparam logic [CFG_W-1:0] CHECK_WORDS_RST = 13'd4096;

    // Register indexes on the configuration channel
    typedef enum logic [IDX_SEL_W-1:0] {
        REG_SKIP_BEGIN  = 2'd0,
        REG_SKIP_END    = 2'd1,
        REG_CHECK_WORDS = 2'd2
    } t_reg_idx;

    // Live register values handed to the datapath
    typedef struct packed {
        logic [CFG_W-1:0] skip_begin;
        logic [CFG_W-1:0] skip_end;
        logic [CFG_W-1:0] check_words;
    } t_cfg;

    // Fold one word into the accumulator: XOR, then sixteen polynomial steps
    function automatic logic [WORD_W-1:0] crc_fold(
        input logic [WORD_W-1:0] acc,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] r;
        r = acc ^ word;
        for (int k = 0; k < WORD_W; k++) begin
            if (r[WORD_W-1]) begin
                r = {r[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[WORD_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/wcrc_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wcrc_cfg
    import wcrc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [IDX_SEL_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Always ready: a write is registered straight into the register file
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the index and hold the register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.skip_begin  <= SKIP_BEGIN_RST;
            r_cfg.skip_end    <= SKIP_END_RST;
            r_cfg.check_words <= CHECK_WORDS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SKIP_BEGIN:  r_cfg.skip_begin  <= i_cfg_data;
                REG_SKIP_END:    r_cfg.skip_end    <= i_cfg_data;
                REG_CHECK_WORDS: r_cfg.check_words <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- design/wcrc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wcrc_core
    import wcrc_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_vld,
    output logic                   o_rdy,
    input  wire logic [WORD_W-1:0] i_data,
    input  wire logic              i_last,
    output logic                   o_res_vld,
    input  wire logic              i_res_rdy,
    output logic [WORD_W-1:0]      o_res_crc
);

    localparam int IDX_W = $clog2(MAX_WORDS + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_WORDS);

    logic              r_in_vld;
    logic [WORD_W-1:0] r_in_data;
    logic              r_in_last;
    logic [WORD_W-1:0] r_acc;
    logic [IDX_W-1:0]  r_idx;

    logic              go;
    logic [CFG_W-1:0]  idx_ext;
    logic              in_window;
    logic              covered;
    logic [WORD_W-1:0] n_acc;

    // Advance the staged item unless it is final and the result slot is full
    assign go    = r_in_vld && (!r_in_last || i_res_rdy);
    assign o_rdy = !r_in_vld || go;

    // Decide coverage and fold
    assign idx_ext   = CFG_W'(r_idx);
    assign in_window = (idx_ext >= i_cfg.skip_begin) && (idx_ext < i_cfg.skip_end);
    assign covered   = (idx_ext < i_cfg.check_words) && !in_window;
    assign n_acc     = covered ? crc_fold(r_acc, r_in_data) : r_acc;

    assign o_res_vld = r_in_vld && r_in_last && i_res_rdy;
    assign o_res_crc = n_acc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_rdy) begin
            r_in_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_in_data <= i_data;
            r_in_last <= i_last;
        end
    end

    // Accumulator and word index; clear both after a final item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_idx <= '0;
        end else if (go) begin
            if (r_in_last) begin
                r_acc <= '0;
                r_idx <= '0;
            end else begin
                r_acc <= n_acc;
                if (r_idx < IDX_MAX) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/word_crc16_with_skip_window_top.sv -----
`timescale 1ns / 1ps
// Word-wide CRC-16 (poly 0x8005, init 0, MSB first, no final XOR) with a skip window.
// Input stream s_axis: one 16-bit image word per item, tlast on the last word.
// Output stream m_axis: one 16-bit CRC per image, given for the item marked tlast.
// Configuration: write skip_begin (index 0), skip_end (1) and check_words (2)
// while no image is in flight; o_cfg_ready is always high.
// A word is folded in when its index is below check_words and outside
// [skip_begin, skip_end); the index saturates at MAX_WORDS.
// Throughput: one word per cycle, except that a tlast word waits while the output
// register is full; the accumulator fold (XOR plus sixteen unrolled polynomial steps)
// is combinational. The CRC reaches m_axis through the input register, then the
// output register.
// Reset (i_rst_n low, synchronous) clears the accumulator, the word index and
// both stages, and loads the register defaults 216, 256 and 4096.
// When m_axis stalls, the CRC waits in the output register; input words keep
// flowing, and a second final word waits in the input register until the
// output register frees.
`default_nettype none
module word_crc16_with_skip_window_top
    import wcrc_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [IDX_SEL_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // Input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [WORD_W-1:0]    s_axis_tdata,   // [15:0] data_word
    input  wire logic                 s_axis_tlast,   // final_word
    // Output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [WORD_W-1:0]         m_axis_tdata    // [15:0] crc_value
);

    t_cfg              cfg;
    logic              res_vld;
    logic              res_rdy;
    logic [WORD_W-1:0] res_crc;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_crc;

    wcrc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wcrc_core #(
        .MAX_WORDS (MAX_WORDS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_vld     (s_axis_tvalid),
        .o_rdy     (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res_crc (res_crc)
    );

    // Output slot is free when empty or being drained this cycle
    assign res_rdy = !r_out_vld || m_axis_tready;

    // Output register: load a finished CRC, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_out_crc <= res_crc;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_crc;

    // A result is only produced into a free output slot
    a_res_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> (!r_out_vld || m_axis_tready))
        else $error("result produced into an occupied output register");

    // A produced CRC shows up on the output the next cycle
    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |=> (m_axis_tvalid && m_axis_tdata == $past(res_crc)))
        else $error("result did not reach the output register");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
